/* rtl/core/rc4_pkg.sv */
package rc4_pkg;

    // Byte and table geometry.
    typedef logic [7:0] byte_t;

    localparam int unsigned PERM_DEPTH = 256;
    localparam int unsigned KEY_DEPTH  = 256;

    // Most key bytes kept; later key bytes are dropped.
    localparam int unsigned KEY_MAX    = 256;

    // Key count runs 0 to KEY_MAX, so it needs one bit over a byte.
    localparam int unsigned KEY_CNT_W  = 9;

    typedef logic [KEY_CNT_W-1:0] key_cnt_t;

    // Request type codes.
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

endpackage

/* rtl/core/rc4_req_if.sv */
interface rc4_req_if;

    logic            valid;
    logic            ready;
    logic            req_type;
    rc4_pkg::byte_t  byte_in;
    logic            key_last;

    modport source (output valid, output req_type, output byte_in, output key_last,
                    input ready);
    modport sink   (input valid, input req_type, input byte_in, input key_last,
                    output ready);

endinterface

/* rtl/core/rc4_rsp_if.sv */
interface rc4_rsp_if;

    logic            valid;
    logic            ready;
    rc4_pkg::byte_t  byte_out;

    modport source (output valid, output byte_out, input ready);
    modport sink   (input valid, input byte_out, output ready);

endinterface

/* rtl/core/rc4_ram.sv */
module rc4_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; a write to the same address in the same cycle is passed through.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/rc4_stream_cipher.sv */
// RC4 stream cipher with the permutation and the key bytes in two RAMs.
// A key item goes to the key RAM unless KEY_MAX bytes are held; the item marked
// key_last runs the key schedule: the read, swap and write-back of each entry.
// A data item steps through read S[i], read S[j], two writes and the read of the
// keystream entry on the single permutation RAM port pair.
// Reset is asynchronous: the permutation reads as identity and count and indices clear.
module rc4_stream_cipher (
    input  logic           clk,
    input  logic           rst_n,
    rc4_req_if.sink        req,
    rc4_rsp_if.source      rsp
);

    import rc4_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_KA   = 4'd1;
    localparam logic [3:0] ST_KB   = 4'd2;
    localparam logic [3:0] ST_KC   = 4'd3;
    localparam logic [3:0] ST_KD   = 4'd4;
    localparam logic [3:0] ST_DB   = 4'd5;
    localparam logic [3:0] ST_DC   = 4'd6;
    localparam logic [3:0] ST_DD   = 4'd7;
    localparam logic [3:0] ST_DE   = 4'd8;

    localparam key_cnt_t KEY_LIMIT = KEY_CNT_W'(KEY_MAX);
    localparam byte_t    LAST_IDX  = 8'(PERM_DEPTH - 1);

    logic [3:0] state_reg, state_next;
    byte_t      i_reg, i_next;
    byte_t      j_reg, j_next;
    byte_t      n_reg, n_next;
    byte_t      kidx_reg, kidx_next;
    key_cnt_t   kcnt_reg, kcnt_next;
    key_cnt_t   klen_reg, klen_next;
    byte_t      si_reg, si_next;
    byte_t      sj_reg, sj_next;
    byte_t      data_reg, data_next;
    logic       out_valid_reg, out_valid_next;
    byte_t      out_byte_reg, out_byte_next;

    // Permutation RAM ports and valid bits (invalid entry reads as its own index).
    logic                  p_we;
    byte_t                 p_waddr, p_wdata, p_raddr, p_rdata;
    byte_t                 p_raddr_reg;
    logic [PERM_DEPTH-1:0] vld_reg;
    logic                  vld_rd_reg;
    logic                  vld_clear;
    byte_t                 perm_val;

    // Key RAM ports.
    logic  k_we;
    byte_t k_waddr, k_raddr, k_rdata;

    key_cnt_t kidx_inc;
    logic     accept;

    rc4_ram #(.WIDTH(8), .DEPTH(PERM_DEPTH)) u_perm_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    rc4_ram #(.WIDTH(8), .DEPTH(KEY_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (req.byte_in),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    assign req.ready    = (state_reg == ST_IDLE);
    assign accept       = req.valid && req.ready;
    assign rsp.valid    = out_valid_reg;
    assign rsp.byte_out = out_byte_reg;

    assign perm_val = vld_rd_reg ? p_rdata : p_raddr_reg;
    assign kidx_inc = {1'b0, kidx_reg} + KEY_CNT_W'(1);
    assign k_raddr  = kidx_next;

    // Sequencer for key loads, the key schedule and data items.
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        kidx_next      = kidx_reg;
        kcnt_next      = kcnt_reg;
        klen_next      = klen_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        data_next      = data_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        p_we           = 1'b0;
        p_waddr        = n_reg;
        p_wdata        = si_reg;
        p_raddr        = p_raddr_reg;
        k_we           = 1'b0;
        k_waddr        = kcnt_reg[7:0];
        vld_clear      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    data_next = req.byte_in;
                    if (req.req_type == REQ_KEY)
                    begin
                        if (kcnt_reg < KEY_LIMIT)
                        begin
                            k_we      = 1'b1;
                            kcnt_next = kcnt_reg + KEY_CNT_W'(1);
                        end
                        if (req.key_last)
                        begin
                            klen_next  = (kcnt_reg < KEY_LIMIT) ?
                                         kcnt_reg + KEY_CNT_W'(1) : kcnt_reg;
                            vld_clear  = 1'b1;
                            n_next     = '0;
                            kidx_next  = '0;
                            j_next     = '0;
                            state_next = ST_KA;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + 8'd1;
                        p_raddr    = i_reg + 8'd1;
                        state_next = ST_DB;
                    end
                end
            end
            ST_KA:
            begin
                p_raddr    = n_reg;
                state_next = ST_KB;
            end
            ST_KB:
            begin
                si_next    = perm_val;
                j_next     = j_reg + perm_val + k_rdata;
                p_raddr    = j_reg + perm_val + k_rdata;
                state_next = ST_KC;
            end
            ST_KC:
            begin
                sj_next    = perm_val;
                p_we       = 1'b1;
                p_waddr    = n_reg;
                p_wdata    = perm_val;
                state_next = ST_KD;
            end
            ST_KD:
            begin
                p_we    = 1'b1;
                p_waddr = j_reg;
                p_wdata = si_reg;
                if (n_reg == LAST_IDX)
                begin
                    kcnt_next  = '0;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    n_next     = n_reg + 8'd1;
                    kidx_next  = (kidx_inc == klen_reg) ? 8'd0 : kidx_inc[7:0];
                    p_raddr    = n_reg + 8'd1;
                    state_next = ST_KB;
                end
            end
            ST_DB:
            begin
                si_next    = perm_val;
                j_next     = j_reg + perm_val;
                p_raddr    = j_reg + perm_val;
                state_next = ST_DC;
            end
            ST_DC:
            begin
                sj_next    = perm_val;
                p_we       = 1'b1;
                p_waddr    = i_reg;
                p_wdata    = perm_val;
                state_next = ST_DD;
            end
            ST_DD:
            begin
                p_we       = 1'b1;
                p_waddr    = j_reg;
                p_wdata    = si_reg;
                p_raddr    = si_reg + sj_reg;
                state_next = ST_DE;
            end
            ST_DE:
            begin
                // Hold here while the previous result still waits.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_byte_next  = data_reg ^ perm_val;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            kidx_reg      <= '0;
            kcnt_reg      <= '0;
            klen_reg      <= KEY_CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            kidx_reg      <= kidx_next;
            kcnt_reg      <= kcnt_next;
            klen_reg      <= klen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Permutation valid bits: cleared at reset and when a key schedule starts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (vld_clear)
        begin
            vld_reg <= '0;
        end
        else if (p_we)
        begin
            vld_reg[p_waddr] <= 1'b1;
        end
    end

    // Payload registers, including the read-side tag of the permutation RAM.
    always_ff @(posedge clk)
    begin
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
        p_raddr_reg  <= p_raddr;
        vld_rd_reg   <= vld_reg[p_raddr] || (p_we && (p_waddr == p_raddr));
    end

endmodule
